/* src/tpar_pkg.sv */
// Shared types and constants for the tensor permute address remap block.
// No dependencies; imported by every module under src.
`timescale 1ns / 1ps

package tpar_pkg;

    localparam int DATA_W       = 32;
    localparam int MAX_DIMS_DEF = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int CNT_W        = $clog2(DATA_W);

    typedef struct packed {
        logic [DATA_W-1:0] index;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* src/tpar_cfg.sv */
// Stride register file: decodes configuration writes into input and output strides.
// Depends on tpar_pkg.
`timescale 1ns / 1ps

module tpar_cfg #(
    parameter int MAX_DIMS = tpar_pkg::MAX_DIMS_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [$clog2(2*MAX_DIMS)-1:0]                i_cfg_index,
    input  logic [tpar_pkg::DATA_W-1:0]                  i_cfg_data,
    output logic [MAX_DIMS-1:0][tpar_pkg::DATA_W-1:0]    o_in_stride,
    output logic [MAX_DIMS-1:0][tpar_pkg::DATA_W-1:0]    o_out_stride
);
    import tpar_pkg::*;

    localparam int IDX_W = $clog2(2*MAX_DIMS);

    logic [MAX_DIMS-1:0][DATA_W-1:0] r_in_stride;
    logic [MAX_DIMS-1:0][DATA_W-1:0] r_out_stride;
    logic [MAX_DIMS-1:0][DATA_W-1:0] n_in_stride;
    logic [MAX_DIMS-1:0][DATA_W-1:0] n_out_stride;

    assign o_cfg_ready  = 1'b1;
    assign o_in_stride  = r_in_stride;
    assign o_out_stride = r_out_stride;

    always_comb begin
        n_in_stride  = r_in_stride;
        n_out_stride = r_out_stride;
        if (i_cfg_valid) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (i_cfg_index == IDX_W'(d)) begin
                    n_in_stride[d] = i_cfg_data;
                end
                if (i_cfg_index == IDX_W'(MAX_DIMS + d)) begin
                    n_out_stride[d] = i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_in_stride[d]  <= DATA_W'(1);
                r_out_stride[d] <= (d == 0) ? DATA_W'(1) : '0;
            end
        end else begin
            r_in_stride  <= n_in_stride;
            r_out_stride <= n_out_stride;
        end
    end

endmodule

/* src/tpar_front.sv */
// Front end: accepts input words, numbers them with the linear index, queues them.
// Depends on tpar_pkg.
`timescale 1ns / 1ps

module tpar_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tpar_pkg::DATA_W-1:0]  i_value,
    input  logic                         i_last,
    input  tpar_pkg::t_q_status          i_q_status,
    output logic                         o_push,
    output tpar_pkg::t_item              o_item
);
    import tpar_pkg::*;

    logic [DATA_W-1:0] r_index;
    logic [DATA_W-1:0] n_index;
    logic              accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    assign o_item.index = r_index;
    assign o_item.value = i_value;
    assign o_item.last  = i_last;

    always_comb begin
        n_index = r_index;
        if (accept) begin
            n_index = i_last ? '0 : r_index + DATA_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
        end else begin
            r_index <= n_index;
        end
    end

    a_index_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_index == '0))
        else $error("linear index did not return to zero after last word");

endmodule

/* src/tpar_fifo.sv */
// Short queue between front and back ends.
// Depends on tpar_pkg.
`timescale 1ns / 1ps

module tpar_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tpar_pkg::t_item      i_item,
    input  logic                 i_pop,
    output tpar_pkg::t_item      o_item,
    output tpar_pkg::t_q_status  o_status
);
    import tpar_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_Q = $clog2(QUEUE_DEPTH + 1);

    t_item             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_Q-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_Q-1:0]  n_count;

    assign o_status.full  = (r_count == CNT_Q'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_Q'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_Q'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_Q'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* src/tpar_back.sv */
// Back end: bit-serial divider per dimension, one multiply and accumulate, output register.
// Depends on tpar_pkg.
`timescale 1ns / 1ps

module tpar_back #(
    parameter int MAX_DIMS = tpar_pkg::MAX_DIMS_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  tpar_pkg::t_q_status                        i_q_status,
    input  tpar_pkg::t_item                            i_item,
    output logic                                       o_pop,
    input  logic [MAX_DIMS-1:0][tpar_pkg::DATA_W-1:0]  i_in_stride,
    input  logic [MAX_DIMS-1:0][tpar_pkg::DATA_W-1:0]  i_out_stride,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic [tpar_pkg::DATA_W-1:0]                o_addr,
    output logic [tpar_pkg::DATA_W-1:0]                o_value,
    output logic                                       o_last
);
    import tpar_pkg::*;

    localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_ACC  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state            r_state,     n_state;
    logic [DIM_W-1:0]  r_dim,       n_dim;
    logic [CNT_W-1:0]  r_cnt,       n_cnt;
    logic [DATA_W-1:0] r_rem,       n_rem;
    logic [DATA_W-1:0] r_dvd,       n_dvd;
    logic [DATA_W-1:0] r_part,      n_part;
    logic [DATA_W-1:0] r_quo,       n_quo;
    logic [DATA_W-1:0] r_prod,      n_prod;
    logic [DATA_W-1:0] r_addr,      n_addr;
    logic [DATA_W-1:0] r_value,     n_value;
    logic              r_last,      n_last;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_addr,  n_out_addr;
    logic [DATA_W-1:0] r_out_value, n_out_value;
    logic              r_out_last,  n_out_last;

    logic [DATA_W-1:0] sel_in;
    logic [DATA_W-1:0] sel_out;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;
    logic              out_free;

    always_comb begin
        sel_in  = '0;
        sel_out = '0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (r_dim == DIM_W'(d)) begin
                sel_in  = i_in_stride[d];
                sel_out = i_out_stride[d];
            end
        end
    end

    assign shifted  = {r_part, r_dvd[DATA_W-1]};
    assign diff     = shifted - {1'b0, sel_in};
    assign fits     = (shifted >= {1'b0, sel_in});
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_dim       = r_dim;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_part      = r_part;
        n_quo       = r_quo;
        n_prod      = r_prod;
        n_addr      = r_addr;
        n_value     = r_value;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop   = 1'b1;
                    n_rem   = i_item.index;
                    n_dvd   = i_item.index;
                    n_part  = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_dim   = '0;
                    n_addr  = '0;
                    n_value = i_item.value;
                    n_last  = i_item.last;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_part = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
                n_quo  = {r_quo[DATA_W-2:0], fits};
                n_dvd  = {r_dvd[DATA_W-2:0], 1'b0};
                n_cnt  = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                // zero stride: coordinate 0, remainder passes on
                if (sel_in == '0) begin
                    n_prod = '0;
                end else begin
                    n_prod = r_quo * sel_out;
                    n_rem  = r_part;
                end
                n_state = S_ACC;
            end
            S_ACC: begin
                n_addr = r_addr + r_prod;
                if (r_dim == DIM_W'(MAX_DIMS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_dim   = r_dim + DIM_W'(1);
                    n_dvd   = r_rem;
                    n_part  = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_addr;
                    n_out_value = r_value;
                    n_out_last  = r_last;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dim       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dim       <= n_dim;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_dvd       <= n_dvd;
        r_part      <= n_part;
        r_quo       <= n_quo;
        r_prod      <= n_prod;
        r_addr      <= n_addr;
        r_value     <= n_value;
        r_last      <= n_last;
        r_out_addr  <= n_out_addr;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_addr  = r_out_addr;
    assign o_value = r_out_value;
    assign o_last  = r_out_last;

    a_part_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && sel_in != '0) |-> (r_part < sel_in))
        else $error("partial remainder not below divisor");

    a_div_count_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt == '0))
        else $error("divider step count not complete");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished word not moved to output register");

endmodule

/* src/tensor_permute_address_remap.sv */
// Top level of the tensor permute address remap block.
// Depends on tpar_pkg, tpar_cfg, tpar_front, tpar_fifo and tpar_back.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis carries one tensor element per word (tdata = element value, tlast
//   marks the final element). m_axis returns one word per input word with the
//   remapped destination address. The linear index counts accepted words and
//   returns to 0 after a word with tlast set.
//   The cfg channel writes strides: index 0..MAX_DIMS-1 are input strides,
//   MAX_DIMS..2*MAX_DIMS-1 output strides, others ignored. Write only while idle.
// Processing:
//   In the back end each word takes, per dimension, a 32-step bit-serial
//   divider, one multiply and one accumulate. The front end and a two-entry
//   queue accept words while the back end is busy; one word is worked on at
//   a time.
// Reset:
//   Synchronous, active low. Input strides go to 1, output stride 0 to 1 and
//   the others to 0, so the address equals the index; the index goes to 0.
// Stall:
//   A stalled m_axis holds its word; the back end waits with its finished
//   result, then the queue fills and s_axis_tready drops.

module tensor_permute_address_remap #(
    parameter int MAX_DIMS = tpar_pkg::MAX_DIMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [tpar_pkg::DATA_W-1:0]         s_axis_tdata,   // [31:0] elem_value
    input  logic                                s_axis_tlast,   // elem_last
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [2*tpar_pkg::DATA_W-1:0]       m_axis_tdata,   // [31:0] dest_address, [63:32] dest_value
    output logic                                m_axis_tlast,   // dest_last
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [$clog2(2*MAX_DIMS)-1:0]       i_cfg_index,
    input  logic [tpar_pkg::DATA_W-1:0]         i_cfg_data
);
    import tpar_pkg::*;

    logic [MAX_DIMS-1:0][DATA_W-1:0] in_stride;
    logic [MAX_DIMS-1:0][DATA_W-1:0] out_stride;
    t_q_status                       q_status;
    t_item                           push_item;
    t_item                           head_item;
    logic                            push;
    logic                            pop;
    logic [DATA_W-1:0]               dest_addr;
    logic [DATA_W-1:0]               dest_value;

    tpar_cfg #(
        .MAX_DIMS (MAX_DIMS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_in_stride  (in_stride),
        .o_out_stride (out_stride)
    );

    tpar_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_value    (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    tpar_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    tpar_back #(
        .MAX_DIMS (MAX_DIMS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_item       (head_item),
        .o_pop        (pop),
        .i_in_stride  (in_stride),
        .i_out_stride (out_stride),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_addr       (dest_addr),
        .o_value      (dest_value),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {dest_value, dest_addr};

endmodule

/* tb/testbench.sv */
// Self-checking testbench for tensor_permute_address_remap: streams tensor elements,
// predicts each permuted destination address and compares every output word.
// Depends on tpar_pkg and the RTL under src; reads no files.
`timescale 1ns / 1ps

module testbench;
    import tpar_pkg::*;

    localparam int DIMS             = MAX_DIMS_DEF;
    localparam int CFG_IDX_W        = $clog2(2 * DIMS);
    localparam int REG_IN_STRIDE0   = 0;
    localparam int REG_OUT_STRIDE0  = DIMS;
    localparam int RANDOM_WORDS     = 1500;
    localparam int SINK_HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int TAIL_CYCLES      = 150;

    typedef logic [DIMS-1:0][DATA_W-1:0] t_stride_vec;

    typedef struct {
        logic [DATA_W-1:0] addr;
        logic [DATA_W-1:0] value;
        logic              last;
    } t_dest_word;

    typedef enum int {PACE_OPEN, PACE_HALF, PACE_SPARSE, PACE_PERIODIC} t_pace;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata = '0;     // [31:0] elem_value
    logic                   s_axis_tlast = 1'b0;   // elem_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [2*DATA_W-1:0]    m_axis_tdata;          // [31:0] dest_address, [63:32] dest_value
    logic                   m_axis_tlast;          // dest_last
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [DATA_W-1:0]      i_cfg_data = '0;

    t_stride_vec            in_stride_q;
    t_stride_vec            out_stride_q;
    logic [DATA_W-1:0]      element_index;
    t_dest_word             pending_dest[$];
    int                     fail_count = 0;
    int                     sent_count = 0;
    int                     burst_left = 0;
    int                     stall_cycles = 0;
    int                     hold_req_count = 0;

    tensor_permute_address_remap #(.MAX_DIMS(DIMS)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [DATA_W-1:0] remap_addr(input logic [DATA_W-1:0] idx);
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] coord;
        logic [DATA_W-1:0] addr;
        rem  = idx;
        addr = '0;
        for (int d = 0; d < DIMS; d++) begin
            coord = '0;
            if (in_stride_q[d] != '0) begin
                coord = rem / in_stride_q[d];
                rem   = rem - coord * in_stride_q[d];
            end
            addr = addr + coord * out_stride_q[d];
        end
        return addr;
    endfunction

    task automatic send_word(input logic [DATA_W-1:0] value, input logic last);
        t_dest_word want;
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 150 : 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        want.addr  = remap_addr(element_index);
        want.value = value;
        want.last  = last;
        pending_dest.insert(pending_dest.size(), want);
        element_index = last ? '0 : element_index + 1'b1;
        sent_count++;
    endtask

    task automatic stop_and_drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_dest.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_strides(input t_stride_vec ins, input t_stride_vec outs);
        logic [CFG_IDX_W-1:0] reg_idx;
        stop_and_drain();
        for (int r = 0; r < 2 * DIMS; r++) begin
            reg_idx = CFG_IDX_W'(r);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx;
            i_cfg_data  <= (r < REG_OUT_STRIDE0) ? ins[r - REG_IN_STRIDE0] : outs[r - REG_OUT_STRIDE0];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            if (r < REG_OUT_STRIDE0)
                in_stride_q[r - REG_IN_STRIDE0] = ins[r - REG_IN_STRIDE0];
            else
                out_stride_q[r - REG_OUT_STRIDE0] = outs[r - REG_OUT_STRIDE0];
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // reset strides: address equals index
    task automatic test_reset_identity();
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'hAAAA_5555, 1'b0);
        send_word(32'h5555_AAAA, 1'b0);
        send_word(32'h8000_0001, 1'b1);
        send_word(32'h1234_5678, 1'b1);
    endtask

    // 2x3 transpose, then a second pass to show the index wrap on last
    task automatic test_transpose();
        t_stride_vec ins;
        t_stride_vec outs;
        ins  = {32'd1, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        outs = {32'd2, 32'd1, 32'd0, 32'd0};
        load_strides(ins, outs);
        for (int e = 0; e < 8; e++)
            send_word($urandom, e == 5 || e == 7);
    endtask

    // extreme strides; products wrap
    task automatic test_overflow();
        t_stride_vec ins;
        t_stride_vec outs;
        ins  = {32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF};
        outs = {32'h8000_0001, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        load_strides(ins, outs);
        for (int e = 0; e < 5; e++)
            send_word($urandom, e == 4);
    endtask

    // zero input stride gives coordinate 0 and passes the remainder on
    task automatic test_zero_in_stride();
        t_stride_vec ins;
        t_stride_vec outs;
        ins  = {32'd1, 32'd0, 32'd4, 32'd0};
        outs = {32'd2, 32'd5, 32'd3, 32'd7};
        load_strides(ins, outs);
        for (int e = 0; e < 6; e++)
            send_word($urandom, e == 5);
    endtask

    // sink holds off while the source keeps offering; input must stall
    task automatic test_sink_holdoff();
        hold_req_count++;
        burst_left = 64;
        for (int e = 0; e < 16; e++)
            send_word($urandom, e == 15);
        stop_and_drain();
    endtask

    // source pauses until every word is back, same settings on both sides
    task automatic test_source_pause();
        for (int e = 0; e < 6; e++)
            send_word($urandom, 1'b0);
        stop_and_drain();
        for (int e = 0; e < 6; e++)
            send_word($urandom, e == 5);
        stop_and_drain();
    endtask

    // well-formed permutes of random shapes, with the odd early last
    task automatic send_tensor_batch();
        int          sz [DIMS];
        int          order [DIMS];
        int          ndims;
        int          acc;
        int          total;
        int          j;
        int          tmp;
        t_stride_vec ins;
        t_stride_vec outs;
        ndims = $urandom_range(1, DIMS);
        for (int d = 0; d < DIMS; d++)
            sz[d] = (d >= DIMS - ndims) ? $urandom_range(1, 4) : 1;
        if (ndims <= 2 && $urandom_range(0, 3) == 0)
            sz[DIMS-1] = $urandom_range(5, 40);
        acc = 1;
        for (int d = DIMS - 1; d >= 0; d--) begin
            if (d >= DIMS - ndims) begin
                ins[d] = acc;
                acc = acc * sz[d];
            end else begin
                ins[d] = ($urandom_range(0, 3) == 0) ? $urandom_range(32'h1000, 32'hFFFF_FFFF)
                                                    : 32'hFFFF_FFFF;
            end
            outs[d] = '0;
        end
        total = acc;
        for (int k = 0; k < ndims; k++)
            order[k] = DIMS - ndims + k;
        for (int k = ndims - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        acc = 1;
        for (int k = ndims - 1; k >= 0; k--) begin
            outs[order[k]] = acc;
            acc = acc * sz[order[k]];
        end
        load_strides(ins, outs);
        repeat ($urandom_range(1, 3)) begin
            for (int e = 0; e < total; e++)
                send_word($urandom, e == total - 1 || $urandom_range(0, 59) == 0);
        end
    endtask

    // arbitrary register contents and random last flags
    task automatic send_raw_batch();
        t_stride_vec ins;
        t_stride_vec outs;
        int          n;
        for (int d = 0; d < DIMS; d++) begin
            case ($urandom_range(0, 3))
                0: ins[d] = $urandom_range(1, 32'hFFFF_FFFF);
                1: ins[d] = $urandom_range(1, 8);
                2: ins[d] = 32'hFFFF_FFFF;
                default: ins[d] = 32'd1;
            endcase
            outs[d] = $urandom;
        end
        load_strides(ins, outs);
        n = $urandom_range(10, 40);
        for (int e = 0; e < n; e++)
            send_word($urandom, e == n - 1 || $urandom_range(0, 15) == 0);
    endtask

    task automatic test_random_traffic();
        while (sent_count < RANDOM_WORDS) begin
            if ($urandom_range(0, 4) == 0)
                send_raw_batch();
            else
                send_tensor_batch();
        end
    endtask

    initial begin
        for (int d = 0; d < DIMS; d++) begin
            in_stride_q[d]  = 32'd1;
            out_stride_q[d] = (d == 0) ? 32'd1 : 32'd0;
        end
        element_index = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_identity();
        test_transpose();
        test_overflow();
        test_zero_in_stride();
        test_sink_holdoff();
        test_source_pause();
        test_random_traffic();

        stop_and_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_dest.size() == 0) begin
            $display("[tensor_permute_address_remap] OK");
        end else begin
            $display("[tensor_permute_address_remap] ERROR");
        end
        $finish;
    end

    initial begin : sink_pacing
        t_pace pace;
        int    pace_left;
        int    phase;
        int    hold_served;
        pace = PACE_OPEN;
        pace_left = 0;
        phase = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req_count != hold_served) begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge i_clk);
                hold_served = hold_req_count;
            end
            if (pace_left == 0) begin
                pace = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(32, 256);
            end
            pace_left--;
            phase++;
            case (pace)
                PACE_OPEN:     m_axis_tready <= 1'b1;
                PACE_HALF:     m_axis_tready <= $urandom_range(0, 1);
                PACE_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) == 0);
                PACE_PERIODIC: m_axis_tready <= (phase % 4 == 0);
                default:       m_axis_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin : check_dest
        t_dest_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_dest.size() == 0) begin
                $error("unexpected word: addr %h value %h last %b",
                       m_axis_tdata[DATA_W-1:0], m_axis_tdata[2*DATA_W-1:DATA_W], m_axis_tlast);
                fail_count++;
            end else begin
                want = pending_dest.pop_front();
                if (m_axis_tdata[DATA_W-1:0] !== want.addr) begin
                    $error("dest_address: expected %h, got %h", want.addr, m_axis_tdata[DATA_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[2*DATA_W-1:DATA_W] !== want.value) begin
                    $error("dest_value: expected %h, got %h",
                           want.value, m_axis_tdata[2*DATA_W-1:DATA_W]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("dest_last: expected %b, got %b", want.last, m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // no handshake on any channel for too long means the block hung
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[tensor_permute_address_remap] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
